FILE: rtl/core/rpn4_pkg.sv
// Shared types, action codes and helpers for the four-level RPN stack ALU.
`default_nettype none

package rpn4_pkg;

  // Q16.16 word width and the number of serial steps of each unit.
  localparam int unsigned QW       = 32;
  localparam int unsigned FracBits = 16;
  localparam int unsigned MulSteps = QW;
  localparam int unsigned DivSteps = QW + FracBits;

  // Action codes carried in the request.
  localparam logic [2:0] ACT_PUSH = 3'd0;
  localparam logic [2:0] ACT_ADD  = 3'd1;
  localparam logic [2:0] ACT_SUB  = 3'd2;
  localparam logic [2:0] ACT_MUL  = 3'd3;
  localparam logic [2:0] ACT_DIV  = 3'd4;

  // One input request.
  typedef struct packed {
    logic        [2:0]    action;
    logic signed [QW-1:0] value;
  } rpn4_req_t;

  // One result: the stack after the step and the two flags.
  typedef struct packed {
    logic signed [QW-1:0] top_x;
    logic signed [QW-1:0] level_y;
    logic signed [QW-1:0] level_z;
    logic signed [QW-1:0] level_t;
    logic                 divide_by_zero;
    logic                 saturated;
  } rpn4_rsp_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [QW-1:0] abs_q(input logic [QW-1:0] v);
    abs_q = v[QW-1] ? (~v + QW'(1)) : v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rpn4_serial_mul.sv
// Bit-serial shift-add multiplier giving the Q16.16 product before clipping.
`default_nettype none

module rpn4_serial_mul import rpn4_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [QW-1:0]  op_a_i,
  input  wire logic signed [QW-1:0]  op_b_i,
  output logic                       done_o,
  output logic        [2*QW-1:0]     res_o
);

  localparam int unsigned CntW = $clog2(MulSteps);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIX  = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [QW-1:0]   hi_q, hi_d;
  logic [QW-1:0]   lo_q, lo_d;
  logic [QW-1:0]   mcand_q, mcand_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  logic [2*QW-1:0] res_q, res_d;
  logic [QW:0]     psum;
  logic [2*QW-1:0] prod_s;

  // One partial product per cycle; the multiplier bits shift out of the low half.
  assign psum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : {(QW+1){1'b0}});
  // Signed product, then an arithmetic shift by the fraction width.
  assign prod_s = neg_q ? (~{hi_q, lo_q} + (2*QW)'(1)) : {hi_q, lo_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          mcand_d = abs_q(op_a_i);
          lo_d    = abs_q(op_b_i);
          hi_d    = '0;
          neg_d   = op_a_i[QW-1] ^ op_b_i[QW-1];
          cnt_d   = '0;
          phase_d = PH_RUN;
        end
      end
      PH_RUN: begin
        hi_d  = psum[QW:1];
        lo_d  = {psum[0], lo_q[QW-1:1]};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(MulSteps - 1)) begin
          phase_d = PH_FIX;
        end
      end
      PH_FIX: begin
        res_d   = {{FracBits{prod_s[2*QW-1]}}, prod_s[2*QW-1:FracBits]};
        done_d  = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Control state is reset; the datapath is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
    neg_q   <= neg_d;
    res_q   <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpn4_serial_div.sv
// Restoring bit-serial divider computing (Y * 2^16) / X truncated toward zero.
`default_nettype none

module rpn4_serial_div import rpn4_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [QW-1:0]  dividend_i,
  input  wire logic signed [QW-1:0]  divisor_i,
  output logic                       done_o,
  output logic        [2*QW-1:0]     res_o
);

  localparam int unsigned CntW = $clog2(DivSteps);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_FIX  = 2'd2;

  logic [1:0]          phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DivSteps-1:0] quo_q, quo_d;
  logic [QW-1:0]       rem_q, rem_d;
  logic [QW-1:0]       dsr_q, dsr_d;
  logic                neg_q, neg_d;
  logic                done_q, done_d;
  logic [2*QW-1:0]     res_q, res_d;
  logic [QW:0]         trial;
  logic [QW+1:0]       diff;
  logic [2*QW-1:0]     quo_ext;

  // Bring down the next dividend bit and try one subtraction of the divisor.
  assign trial   = {rem_q, quo_q[DivSteps-1]};
  assign diff    = {1'b0, trial} - {2'b00, dsr_q};
  assign quo_ext = {{(2*QW-DivSteps){1'b0}}, quo_q};

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          dsr_d   = abs_q(divisor_i);
          quo_d   = {abs_q(dividend_i), {FracBits{1'b0}}};
          rem_d   = '0;
          neg_d   = dividend_i[QW-1] ^ divisor_i[QW-1];
          cnt_d   = '0;
          phase_d = PH_RUN;
        end
      end
      PH_RUN: begin
        // The remainder stays below the divisor, so it fits one word.
        if (!diff[QW+1]) begin
          rem_d = diff[QW-1:0];
          quo_d = {quo_q[DivSteps-2:0], 1'b1};
        end else begin
          rem_d = trial[QW-1:0];
          quo_d = {quo_q[DivSteps-2:0], 1'b0};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          phase_d = PH_FIX;
        end
      end
      PH_FIX: begin
        res_d   = neg_q ? (~quo_ext + (2*QW)'(1)) : quo_ext;
        done_d  = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

FILE: rtl/core/rpn_four_level_stack_alu.sv
// Four-level RPN stack ALU on signed Q16.16 numbers with serial multiply and divide.
//
//   Channel  Handshake                 Payload      Direction
//   input    in_valid_i / in_ready_o   in_req_i     one request per stack step
//   output   out_valid_o / out_ready_i out_rsp_o    one result per request
//
// Push, add, subtract, unused codes and a divide by zero go from acceptance straight
// to write-back; multiply first waits for the 32 steps of the shift-add multiplier;
// divide first waits for the 48 quotient bits of the restoring divider.
// One request is in work at a time; a new one is taken while the previous result
// waits in the output register, and write-back stalls until that register is free.
// Reset clears the stack to zero and empties the output register.
`default_nettype none

module rpn_four_level_stack_alu import rpn4_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rpn4_req_t in_req_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rpn4_rsp_t      out_rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [2:0]           act_q;
  logic signed [QW-1:0] val_q;
  logic                 dz_q;
  logic [2*QW-1:0]      r_q;
  logic signed [QW-1:0] x_q, y_q, z_q, t_q;
  logic signed [QW-1:0] x_d, y_d, z_d, t_d;
  rpn4_rsp_t            out_q;
  logic                 out_valid_q;

  logic            accept;
  logic            mul_start, div_start;
  logic            mul_done, div_done;
  logic [2*QW-1:0] mul_res, div_res;
  logic            out_free;
  logic            wb_fire;
  logic [QW:0]     addsub;
  logic [2*QW-1:0] arith;
  logic            fits;
  logic [QW-1:0]   clipped;
  logic            is_arith;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign mul_start  = accept && (in_req_i.action == ACT_MUL);
  assign div_start  = accept && (in_req_i.action == ACT_DIV) && (x_q != '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign wb_fire    = (state_q == ST_WB) && out_free;

  rpn4_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (y_q),
    .op_b_i  (x_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  rpn4_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (y_q),
    .divisor_i  (x_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // Sequencer: accept, wait for a serial unit if needed, then write back.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (mul_start || div_start) begin
          state_d = ST_BUSY;
        end else if (accept) begin
          state_d = ST_WB;
        end
      end
      ST_BUSY: begin
        if (mul_done || div_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Add and subtract are exact in 33 bits; the serial units deliver 64-bit results.
  always_comb begin
    addsub = '0;
    arith  = r_q;
    unique case (act_q)
      ACT_ADD: begin
        addsub = {y_q[QW-1], y_q} + {x_q[QW-1], x_q};
        arith  = {{(QW-1){addsub[QW]}}, addsub};
      end
      ACT_SUB: begin
        addsub = {y_q[QW-1], y_q} - {x_q[QW-1], x_q};
        arith  = {{(QW-1){addsub[QW]}}, addsub};
      end
      default: begin
        arith = r_q;
      end
    endcase
  end

  // Saturate to the Q16.16 range when the upper bits are not a pure sign extension.
  assign fits    = (&arith[2*QW-1:QW-1]) || !(|arith[2*QW-1:QW-1]);
  assign clipped = fits ? arith[QW-1:0] :
                   (arith[2*QW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}});
  assign is_arith = !dz_q && ((act_q == ACT_ADD) || (act_q == ACT_SUB) ||
                              (act_q == ACT_MUL) || (act_q == ACT_DIV));

  // New stack contents for the request being written back.
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    t_d = t_q;
    if (act_q == ACT_PUSH) begin
      t_d = z_q;
      z_d = y_q;
      y_d = x_q;
      x_d = val_q;
    end else if (is_arith) begin
      x_d = clipped;
      y_d = z_q;
      z_d = t_q;
    end
  end

  // Control state and the stack itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      z_q         <= '0;
      t_q         <= '0;
    end else begin
      state_q <= state_d;
      if (wb_fire) begin
        out_valid_q <= 1'b1;
        x_q         <= x_d;
        y_q         <= y_d;
        z_q         <= z_d;
        t_q         <= t_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture, unit result capture and the output register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_req_i.action;
      val_q <= in_req_i.value;
      dz_q  <= (in_req_i.action == ACT_DIV) && (x_q == '0);
    end
    if (state_q == ST_BUSY) begin
      if (mul_done) begin
        r_q <= mul_res;
      end else if (div_done) begin
        r_q <= div_res;
      end
    end
    if (wb_fire) begin
      out_q.top_x          <= x_d;
      out_q.level_y        <= y_d;
      out_q.level_z        <= z_d;
      out_q.level_t        <= t_d;
      out_q.divide_by_zero <= dz_q;
      out_q.saturated      <= is_arith && !fits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire
